// ----- sv/uwt_pkg.sv -----
// ----------------------------------------------------------------------------
// UID whitelist table package
// Shared types, codes and constants of the card UID whitelist table.
// ----------------------------------------------------------------------------
package uwt_pkg;

  // Default table geometry.
  localparam int MaxEntriesDefault = 16;
  localparam int IdBytesDefault    = 5;

  // Fixed field widths of the command and response beats.
  localparam int OpcodeW     = 3;
  localparam int CardIdW     = 40;
  localparam int MarkerW     = 8;
  localparam int StatusW     = 2;
  localparam int EntryCountW = 5;

  // Marker byte of a valid stored record.
  localparam logic [MarkerW-1:0] RecordMark = 8'hA5;

  typedef enum logic [OpcodeW-1:0] {
    OP_CLEAR    = 3'd0,
    OP_LOAD     = 3'd1,
    OP_LOOKUP   = 3'd2,
    OP_REGISTER = 3'd3,
    OP_DELETE   = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STAT_NONE    = 2'd0,
    STAT_STORED  = 2'd1,
    STAT_WIPED   = 2'd2,
    STAT_CLEARED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic [OpcodeW-1:0] opcode;
    logic [CardIdW-1:0] card_id;
    logic [MarkerW-1:0] record_marker;
  } cmd_t;

  typedef struct packed {
    logic                   hit;
    logic [StatusW-1:0]     status;
    logic [EntryCountW-1:0] entry_count;
  } rsp_t;

  // Report of the match scanner to the sequencer.
  typedef struct packed {
    logic done;
    logic found;
  } match_stat_t;

endpackage

// ----- sv/uid_whitelist_table_core.sv -----
// ----------------------------------------------------------------------------
// UID whitelist table core
// Packed table of card UIDs with clear, reload, lookup, register and delete.
// ----------------------------------------------------------------------------
// Usage: a command beat on cmd_i is taken at a rising edge where start is high
// and busy is low. Each command produces exactly one response beat on rsp_o,
// marked by done_o for a single cycle; the receiver cannot hold it off, so it
// must capture the beat in that cycle.
// Timing: the match scan reads one valid entry per cycle through the single
// memory read port and one shared comparator, and it stops at the first
// match. A delete that hits then moves every later entry down one slot at
// one entry per cycle. busy stays high from acceptance until done_o, and a
// new command may be started in the cycle done_o is high.
// Reset clears the entry count and the sequencer; the entry memory itself is
// not cleared, since only slots below the count are ever read.
// ----------------------------------------------------------------------------
module uid_whitelist_table_core #(
  parameter int MaxEntries = uwt_pkg::MaxEntriesDefault,
  parameter int IdBytes    = uwt_pkg::IdBytesDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  uwt_pkg::cmd_t cmd_i,
  output logic          done_o,
  output uwt_pkg::rsp_t rsp_o
);

  // Stored UIDs are as wide as the configured byte count, capped by the port.
  localparam int IdW     = (8 * IdBytes > uwt_pkg::CardIdW) ? uwt_pkg::CardIdW
                                                            : 8 * IdBytes;
  localparam int IdxW    = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CntW    = $clog2(MaxEntries + 1);
  localparam int CntOutW = uwt_pkg::EntryCountW;
  localparam logic [CntW-1:0] FullCount = CntW'(MaxEntries);

  uwt_pkg::state_e state_q, state_d;

  uwt_pkg::cmd_t   cmd_q;
  logic [IdW-1:0]  key_q;
  logic [CntW-1:0] count_q, count_d;
  logic            found_q, found_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic [CntW-1:0] sh_ptr_q, sh_ptr_d;
  logic            wr_pend_q, wr_pend_d;
  logic [IdxW-1:0] wr_addr_q, wr_addr_d;
  uwt_pkg::rsp_t   rsp_q, rsp_d;
  logic            done_q, done_d;

  logic            accept;
  logic            full;
  logic [CntW-1:0] next_slot;

  // Memory ports.
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [IdW-1:0]  mem_wdata;
  logic            mem_re;
  logic [IdxW-1:0] mem_raddr;
  logic [IdW-1:0]  mem_rdata;

  // Match scanner ports.
  logic                 m_rd_en;
  logic [IdxW-1:0]      m_rd_addr;
  uwt_pkg::match_stat_t m_stat;
  logic [IdxW-1:0]      m_pos;

  assign accept    = start && !busy;
  assign busy      = (state_q != uwt_pkg::ST_IDLE);
  assign full      = (count_q == FullCount);
  assign next_slot = CntW'(pos_q) + 1'b1;

  uwt_id_mem #(
    .Depth (MaxEntries),
    .Width (IdW),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  uwt_match #(
    .IdW  (IdW),
    .IdxW (IdxW),
    .CntW (CntW)
  ) u_match (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .key_i     (key_q),
    .count_i   (count_q),
    .rdata_i   (mem_rdata),
    .rd_en_o   (m_rd_en),
    .rd_addr_o (m_rd_addr),
    .stat_o    (m_stat),
    .pos_o     (m_pos)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      uwt_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = uwt_pkg::ST_SCAN;
        end
      end
      uwt_pkg::ST_SCAN: begin
        if (m_stat.done) begin
          // A hit on a delete with later entries behind it needs a shift.
          if ((cmd_q.opcode == uwt_pkg::OP_DELETE) && m_stat.found &&
              ((CntW'(m_pos) + 1'b1) < count_q)) begin
            state_d = uwt_pkg::ST_SHIFT;
          end else begin
            state_d = uwt_pkg::ST_COMMIT;
          end
        end
      end
      uwt_pkg::ST_SHIFT: begin
        if (sh_ptr_q >= count_q) begin
          state_d = uwt_pkg::ST_COMMIT;
        end
      end
      uwt_pkg::ST_COMMIT: begin
        state_d = uwt_pkg::ST_IDLE;
      end
      default: begin
        state_d = uwt_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath control of the sequencer.
  always_comb begin
    count_d   = count_q;
    found_d   = found_q;
    pos_d     = pos_q;
    sh_ptr_d  = sh_ptr_q;
    wr_pend_d = 1'b0;
    wr_addr_d = wr_addr_q;
    rsp_d     = rsp_q;
    done_d    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = key_q;
    mem_re    = 1'b0;
    mem_raddr = m_rd_addr;

    case (state_q)
      uwt_pkg::ST_IDLE: begin
      end
      uwt_pkg::ST_SCAN: begin
        mem_re    = m_rd_en;
        mem_raddr = m_rd_addr;
        if (m_stat.done) begin
          found_d  = m_stat.found;
          pos_d    = m_pos;
          sh_ptr_d = CntW'(m_pos) + 1'b1;
        end
      end
      uwt_pkg::ST_SHIFT: begin
        // Read slot k and write it back to slot k-1 in the following cycle.
        if (wr_pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr_q;
          mem_wdata = mem_rdata;
        end
        if (sh_ptr_q < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = sh_ptr_q[IdxW-1:0];
          wr_pend_d = 1'b1;
          wr_addr_d = IdxW'(sh_ptr_q - 1'b1);
          sh_ptr_d  = sh_ptr_q + 1'b1;
        end
      end
      uwt_pkg::ST_COMMIT: begin
        rsp_d.hit    = found_q;
        rsp_d.status = uwt_pkg::STAT_NONE;
        case (cmd_q.opcode)
          uwt_pkg::OP_CLEAR: begin
            count_d      = '0;
            rsp_d.status = uwt_pkg::STAT_CLEARED;
          end
          uwt_pkg::OP_LOAD: begin
            if ((cmd_q.record_marker == uwt_pkg::RecordMark) && (key_q != '0) &&
                !full) begin
              mem_we       = 1'b1;
              mem_waddr    = count_q[IdxW-1:0];
              count_d      = count_q + 1'b1;
              rsp_d.status = uwt_pkg::STAT_STORED;
            end
          end
          uwt_pkg::OP_REGISTER: begin
            if (!found_q) begin
              mem_we = 1'b1;
              if (!full) begin
                mem_waddr    = count_q[IdxW-1:0];
                count_d      = count_q + 1'b1;
                rsp_d.status = uwt_pkg::STAT_STORED;
              end else begin
                // Full table: start over with the new UID alone.
                mem_waddr    = '0;
                count_d      = CntW'(1);
                rsp_d.status = uwt_pkg::STAT_WIPED;
              end
            end
          end
          uwt_pkg::OP_DELETE: begin
            if (found_q) begin
              count_d      = count_q - 1'b1;
              rsp_d.status = uwt_pkg::STAT_STORED;
            end
          end
          default: begin
          end
        endcase
        rsp_d.entry_count = CntOutW'(count_d);
        done_d            = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= uwt_pkg::ST_IDLE;
      count_q   <= '0;
      wr_pend_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      wr_pend_q <= wr_pend_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      key_q <= cmd_i.card_id[IdW-1:0];
    end
    found_q   <= found_d;
    pos_q     <= pos_d;
    sh_ptr_q  <= sh_ptr_d;
    wr_addr_q <= wr_addr_d;
    rsp_q     <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // The response beat follows the commit step directly.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == uwt_pkg::ST_COMMIT))
    else $error("response beat without a commit step");

  // The entry count never passes the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCount)
    else $error("entry count beyond table depth");

  // An accepted command always starts a match scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == uwt_pkg::ST_SCAN))
    else $error("accepted command did not start a scan");

  // A wipe leaves exactly the new UID in the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status == uwt_pkg::STAT_WIPED)) |-> (rsp_o.entry_count == CntOutW'(1)))
    else $error("wipe left a count other than one");

  // The shift only starts one slot past the matched entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == uwt_pkg::ST_SHIFT) && !$past(state_q == uwt_pkg::ST_SHIFT))
      |-> (sh_ptr_q == next_slot) && found_q)
    else $error("shift started at the wrong slot");

endmodule

// ----- sv/uwt_id_mem.sv -----
// ----------------------------------------------------------------------------
// UID whitelist table entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module uwt_id_mem #(
  parameter int Depth = uwt_pkg::MaxEntriesDefault,
  parameter int Width = uwt_pkg::CardIdW,
  parameter int AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/uwt_match.sv -----
// ----------------------------------------------------------------------------
// UID whitelist table match scanner
// Walks the valid entries through the memory read port, one per cycle, and
// compares each against the key with a single shared comparator.
// ----------------------------------------------------------------------------
module uwt_match #(
  parameter int IdW  = uwt_pkg::CardIdW,
  parameter int IdxW = 4,
  parameter int CntW = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [IdW-1:0]        key_i,
  input  logic [CntW-1:0]       count_i,
  input  logic [IdW-1:0]        rdata_i,
  output logic                  rd_en_o,
  output logic [IdxW-1:0]       rd_addr_o,
  output uwt_pkg::match_stat_t  stat_o,
  output logic [IdxW-1:0]       pos_o
);

  logic            active_q, active_d;
  logic [CntW-1:0] scan_ptr_q, scan_ptr_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0] cmp_ptr_q, cmp_ptr_d;
  logic            hit_now;
  logic            more;
  logic            done;

  // The read issued last cycle is compared now; reads stop at the first hit.
  assign hit_now = cmp_vld_q && (rdata_i == key_i);
  assign more    = scan_ptr_q < count_i;
  assign done    = active_q && (hit_now || (!cmp_vld_q && !more));
  assign rd_en_o = active_q && more && !hit_now;
  assign rd_addr_o = scan_ptr_q[IdxW-1:0];

  always_comb begin
    active_d   = active_q;
    scan_ptr_d = scan_ptr_q;
    cmp_vld_d  = rd_en_o;
    cmp_ptr_d  = cmp_ptr_q;
    if (start_i) begin
      active_d   = 1'b1;
      scan_ptr_d = '0;
      cmp_vld_d  = 1'b0;
    end else begin
      if (rd_en_o) begin
        scan_ptr_d = scan_ptr_q + 1'b1;
        cmp_ptr_d  = scan_ptr_q[IdxW-1:0];
      end
      if (done) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      scan_ptr_q <= '0;
      cmp_vld_q  <= 1'b0;
    end else begin
      active_q   <= active_d;
      scan_ptr_q <= scan_ptr_d;
      cmp_vld_q  <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_ptr_q <= cmp_ptr_d;
  end

  assign stat_o.done  = done;
  assign stat_o.found = hit_now;
  assign pos_o        = cmp_ptr_q;

endmodule
